>>> design/brfo_pkg.sv
// Shared types and constants for the byte ring FIFO with overwrite.
package brfo_pkg;

  localparam int unsigned ADDR_BITS_DEF = 10;
  localparam int unsigned DATA_W        = 8;
  localparam int unsigned AMT_W         = 11;
  localparam int unsigned ACT_W         = 3;
  localparam int unsigned CFG_W         = 4;

  localparam logic [CFG_W-1:0] DEPTH_RST = CFG_W'(10);

  typedef enum logic [ACT_W-1:0] {
    ACT_WRITE   = 3'd0,
    ACT_READ    = 3'd1,
    ACT_PEEK    = 3'd2,
    ACT_DISCARD = 3'd3,
    ACT_CLEAR   = 3'd4
  } action_e;

endpackage

>>> design/byte_ring_fifo_overwrite_top.sv
// Byte ring FIFO with overwrite of the oldest byte: top level.
//
// Input channel (in_valid_i / in_stall_o) carries one item: an action
// (write, read, peek, discard, clear), a data byte and an amount. The
// output channel (out_valid_o / out_stall_i) returns one result per item:
// the byte read or peeked with its valid flag, the moved count, the
// overwrite flag, and the fill level and free space after the item.
// The result is shown in the cycle after the item is
// accepted. Throughput is one item per cycle; the ring memory has one write
// and one registered read port, and the pointers update in the cycle of
// acceptance. When the receiver stalls, the result register holds and the
// input stalls until the result is taken, then one item per cycle resumes.
// The config channel (cfg_valid_i / cfg_ready_o) writes depth_log2 and
// clears both pointers; it is always ready.
// Reset clears the pointers and sets depth_log2 to 10. The ring memory is
// not cleared, so the block accepts items from the first cycle after reset.
module byte_ring_fifo_overwrite_top #(
  parameter int unsigned ADDR_BITS = brfo_pkg::ADDR_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [brfo_pkg::ACT_W-1:0]  action_i,
  input  logic [brfo_pkg::DATA_W-1:0] data_in_i,
  input  logic [brfo_pkg::AMT_W-1:0]  amount_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [brfo_pkg::DATA_W-1:0] read_byte_o,
  output logic                        byte_valid_o,
  output logic [brfo_pkg::AMT_W-1:0]  moved_count_o,
  output logic                        overwrote_o,
  output logic [brfo_pkg::AMT_W-1:0]  fill_level_o,
  output logic [brfo_pkg::AMT_W-1:0]  free_space_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [brfo_pkg::CFG_W-1:0]  cfg_data_i
);
  import brfo_pkg::*;

  localparam int unsigned PW    = ADDR_BITS + 1;
  localparam int unsigned CW    = (PW > AMT_W) ? PW : AMT_W;
  localparam int unsigned DW    = $clog2(ADDR_BITS + 1);
  localparam int unsigned DEPTH = 1 << ADDR_BITS;
  localparam logic [4:0]  MAXD  = 5'(ADDR_BITS);

  logic [DATA_W-1:0]    mem_q [DEPTH];
  logic [DATA_W-1:0]    rdata_q;
  logic [PW-1:0]        head_q, head_d, tail_q, tail_d;
  logic [CFG_W-1:0]     depth_q;
  logic                 out_vld_q, bvalid_q, bvalid_d, over_q, over_d;
  logic [AMT_W-1:0]     moved_q, fill_q, free_q;
  logic [CW-1:0]        moved_d;
  logic [PW-1:0]        lvl, lvl_d, free_d, cap;
  logic [DW-1:0]        dcl;
  logic [ADDR_BITS-1:0] amask, raddr, waddr;
  logic                 mem_we, in_acc, cfg_acc;
  logic [CW-1:0]        amt_c, lvl_c;
  action_e              act;

  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign in_stall_o  = out_vld_q && out_stall_i;
  assign in_acc      = in_valid_i && !in_stall_o;

  always_comb begin
    if (depth_q == '0) begin
      dcl = DW'(1);
    end else if ({1'b0, depth_q} > MAXD) begin
      dcl = DW'(ADDR_BITS);
    end else begin
      dcl = DW'(depth_q);
    end
  end

  assign cap   = PW'(1) << dcl;
  assign amask = ADDR_BITS'(cap - PW'(1));
  assign lvl   = tail_q - head_q;
  assign amt_c = CW'(amount_i);
  assign lvl_c = CW'(lvl);
  assign act   = action_e'(action_i);
  assign waddr = ADDR_BITS'(tail_q) & amask;

  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    mem_we   = 1'b0;
    bvalid_d = 1'b0;
    over_d   = 1'b0;
    moved_d  = '0;
    raddr    = ADDR_BITS'(head_q) & amask;
    unique case (act)
      ACT_WRITE: begin
        mem_we  = 1'b1;
        tail_d  = tail_q + PW'(1);
        moved_d = CW'(1);
        if (lvl >= cap) begin
          head_d = head_q + PW'(1);
          over_d = 1'b1;
        end
      end
      ACT_READ: begin
        if (lvl != '0) begin
          bvalid_d = 1'b1;
          moved_d  = CW'(1);
          head_d   = head_q + PW'(1);
        end
      end
      ACT_PEEK: begin
        raddr = (ADDR_BITS'(head_q) + ADDR_BITS'(amount_i)) & amask;
        if (amt_c < lvl_c) begin
          bvalid_d = 1'b1;
          moved_d  = CW'(1);
        end
      end
      ACT_DISCARD: begin
        moved_d = (amt_c < lvl_c) ? amt_c : lvl_c;
        head_d  = head_q + PW'(moved_d);
      end
      ACT_CLEAR: begin
        head_d = '0;
        tail_d = '0;
      end
      default: begin
      end
    endcase
  end

  assign lvl_d  = tail_d - head_d;
  assign free_d = (lvl_d <= cap) ? (cap - lvl_d) : '0;

  always_ff @(posedge clk_i) begin
    if (in_acc && mem_we) begin
      mem_q[waddr] <= data_in_i;
    end
    if (in_acc) begin
      rdata_q <= mem_q[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      tail_q    <= '0;
      depth_q   <= DEPTH_RST;
      out_vld_q <= 1'b0;
      bvalid_q  <= 1'b0;
      over_q    <= 1'b0;
    end else begin
      if (cfg_acc) begin
        depth_q <= cfg_data_i;
        head_q  <= '0;
        tail_q  <= '0;
      end else if (in_acc) begin
        head_q <= head_d;
        tail_q <= tail_d;
      end
      if (in_acc) begin
        out_vld_q <= 1'b1;
        bvalid_q  <= bvalid_d;
        over_q    <= over_d;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      moved_q <= AMT_W'(moved_d);
      fill_q  <= AMT_W'(lvl_d);
      free_q  <= AMT_W'(free_d);
    end
  end

  assign out_valid_o   = out_vld_q;
  assign read_byte_o   = bvalid_q ? rdata_q : '0;
  assign byte_valid_o  = bvalid_q;
  assign moved_count_o = moved_q;
  assign overwrote_o   = over_q;
  assign fill_level_o  = fill_q;
  assign free_space_o  = free_q;

  // Fill never exceeds the capacity in use.
  a_fill_in_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lvl <= cap)
    else $error("fill level above capacity");

  // A read of an empty ring yields no data.
  a_empty_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && act == ACT_READ && lvl == '0) |=> (out_vld_q && !bvalid_q))
    else $error("read of empty ring returned data");

  // A result never carries both data and an overwrite.
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !(bvalid_q && over_q))
    else $error("byte valid and overwrite both set");

endmodule

>>> bench/tb.sv
// Testbench for byte_ring_fifo_overwrite_top: random items checked against a ring predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import brfo_pkg::*;

  localparam int unsigned STORE_SIZE = 1 << ADDR_BITS_DEF;
  localparam logic [ACT_W-1:0] ACT_SPARE_FIRST = 3'd5;
  localparam logic [ACT_W-1:0] ACT_SPARE_LAST = 3'd7;
  localparam int unsigned STUCK_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned HOLD_AT = 600;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned NUM_PHASES = 16;
  localparam int unsigned FILL_PHASE = 14;
  localparam int unsigned FILL_ITEMS = 1150;
  localparam int unsigned PHASE_ITEMS = 14;
  localparam int unsigned CALM_PHASE = 2;
  localparam int unsigned CALM_ITEMS = 300;
  localparam logic [CFG_W-1:0] PHASE_DEPTH [NUM_PHASES] =
    '{4'd1, 4'd2, 4'd3, 4'd0, 4'd4, 4'd5, 4'd13, 4'd7,
      4'd6, 4'd8, 4'd9, 4'd12, 4'd14, 4'd11, 4'd15, 4'd10};

  typedef struct packed {
    logic [DATA_W-1:0] rd_byte;
    logic              rd_valid;
    logic [AMT_W-1:0]  moved;
    logic              overwrote;
    logic [AMT_W-1:0]  fill;
    logic [AMT_W-1:0]  free_space;
  } ring_result_t;

  class ring_predictor;
    logic [DATA_W-1:0] store [STORE_SIZE];
    logic [AMT_W-1:0]  head;
    logic [AMT_W-1:0]  tail;
    logic [CFG_W-1:0]  depth;
    ring_result_t      expected_q[$];
    int unsigned       failures;

    function new();
      head = '0;
      tail = '0;
      depth = DEPTH_RST;
      failures = 0;
    endfunction

    function int unsigned capacity();
      int unsigned d;
      d = depth;
      if (d < 1) d = 1;
      if (d > ADDR_BITS_DEF) d = ADDR_BITS_DEF;
      return 1 << d;
    endfunction

    function int unsigned level();
      logic [AMT_W-1:0] diff;
      diff = tail - head;
      return diff;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void set_depth(logic [CFG_W-1:0] v);
      depth = v;
      head = '0;
      tail = '0;
    endfunction

    function void accept_item(logic [ACT_W-1:0] act, logic [DATA_W-1:0] data,
                              logic [AMT_W-1:0] amt);
      ring_result_t res;
      int unsigned cap, amask, lvl, moved;
      res = '0;
      cap = capacity();
      amask = cap - 1;
      lvl = level();
      case (act)
        ACT_WRITE: begin
          store[tail & amask] = data;
          tail = tail + 1'b1;
          if (lvl >= cap) begin
            head = head + 1'b1;
            res.overwrote = 1'b1;
          end
          res.moved = AMT_W'(1);
        end
        ACT_READ: begin
          if (lvl > 0) begin
            res.rd_byte = store[head & amask];
            head = head + 1'b1;
            res.rd_valid = 1'b1;
            res.moved = AMT_W'(1);
          end
        end
        ACT_PEEK: begin
          if (amt < lvl) begin
            res.rd_byte = store[(head + amt) & amask];
            res.rd_valid = 1'b1;
            res.moved = AMT_W'(1);
          end
        end
        ACT_DISCARD: begin
          moved = (amt < lvl) ? amt : lvl;
          head = head + AMT_W'(moved);
          res.moved = AMT_W'(moved);
        end
        ACT_CLEAR: begin
          head = '0;
          tail = '0;
        end
        default: ;
      endcase
      lvl = level();
      res.fill = AMT_W'(lvl);
      res.free_space = (lvl <= cap) ? AMT_W'(cap - lvl) : '0;
      expected_q.push_back(res);
    endfunction

    function void check_result(ring_result_t got);
      ring_result_t want;
      if (expected_q.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("mismatch: result with no item pending, fill %0d", got.fill);
        return;
      end
      want = expected_q.pop_front();
      if (got.rd_byte !== want.rd_byte || got.rd_valid !== want.rd_valid ||
          got.moved !== want.moved || got.overwrote !== want.overwrote ||
          got.fill !== want.fill || got.free_space !== want.free_space) begin
        failures++;
        if (failures <= MAX_REPORTS) begin
          $display("mismatch: exp byte %0h valid %0d moved %0d over %0d fill %0d free %0d",
                   want.rd_byte, want.rd_valid, want.moved, want.overwrote,
                   want.fill, want.free_space);
          $display("          got byte %0h valid %0d moved %0d over %0d fill %0d free %0d",
                   got.rd_byte, got.rd_valid, got.moved, got.overwrote,
                   got.fill, got.free_space);
        end
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [ACT_W-1:0]  action_i = '0;
  logic [DATA_W-1:0] data_in_i = '0;
  logic [AMT_W-1:0]  amount_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [DATA_W-1:0] read_byte_o;
  logic              byte_valid_o;
  logic [AMT_W-1:0]  moved_count_o;
  logic              overwrote_o;
  logic [AMT_W-1:0]  fill_level_o;
  logic [AMT_W-1:0]  free_space_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [CFG_W-1:0]  cfg_data_i = '0;

  ring_predictor pred;
  bit            calm = 1'b0;
  int unsigned   n_results = 0;

  byte_ring_fifo_overwrite_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .data_in_i     (data_in_i),
    .amount_i      (amount_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .read_byte_o   (read_byte_o),
    .byte_valid_o  (byte_valid_o),
    .moved_count_o (moved_count_o),
    .overwrote_o   (overwrote_o),
    .fill_level_o  (fill_level_o),
    .free_space_o  (free_space_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // valid stays high across back-to-back items; only an idle gap lowers it
  task automatic push_item(input logic [ACT_W-1:0] act, input logic [DATA_W-1:0] data,
                           input logic [AMT_W-1:0] amt);
    while (!calm && $urandom_range(99) < 11) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= act;
    data_in_i <= data;
    amount_i <= amt;
    do @(posedge clk_i); while (in_stall_o);
    pred.accept_item(act, data, amt);
  endtask

  task automatic program_depth(input logic [CFG_W-1:0] v);
    in_valid_i <= 1'b0;
    while (pred.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    pred.set_depth(v);
  endtask

  task automatic random_item(input bit filling);
    logic [ACT_W-1:0] act;
    logic [AMT_W-1:0] amt;
    int unsigned pick, lvl;
    pick = $urandom_range(99);
    lvl = pred.level();
    amt = AMT_W'($urandom);
    if (filling) begin
      if (pick < 97) act = ACT_WRITE;
      else if (pick < 98) act = ACT_READ;
      else act = ACT_PEEK;
    end else begin
      if (pick < 45) act = ACT_WRITE;
      else if (pick < 67) act = ACT_READ;
      else if (pick < 82) act = ACT_PEEK;
      else if (pick < 93) act = ACT_DISCARD;
      else if (pick < 97) act = ACT_CLEAR;
      else act = ACT_W'($urandom_range(ACT_SPARE_LAST, ACT_SPARE_FIRST));
    end
    // mostly offsets near the data, sometimes just past it
    if (act == ACT_PEEK && $urandom_range(3) != 0) amt = AMT_W'($urandom_range(lvl));
    if (act == ACT_DISCARD && $urandom_range(9) < 7) amt = AMT_W'($urandom_range(lvl + 1));
    push_item(act, DATA_W'($urandom), amt);
  endtask

  initial begin
    int unsigned n;
    pred = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    push_item(ACT_READ, 8'h00, 11'd0);
    push_item(ACT_PEEK, 8'hFF, 11'd0);
    push_item(ACT_DISCARD, 8'h00, 11'h7FF);
    push_item(ACT_WRITE, 8'h00, 11'h7FF);
    push_item(ACT_WRITE, 8'hFF, 11'd0);
    push_item(ACT_WRITE, 8'hA5, 11'd0);
    push_item(ACT_PEEK, 8'h00, 11'd0);
    push_item(ACT_PEEK, 8'h00, 11'd2);
    push_item(ACT_PEEK, 8'h00, 11'd3);
    push_item(ACT_PEEK, 8'h00, 11'h7FF);
    push_item(ACT_READ, 8'h00, 11'd0);
    push_item(ACT_DISCARD, 8'h00, 11'd0);
    push_item(ACT_DISCARD, 8'h00, 11'h7FF);
    push_item(ACT_WRITE, 8'h5A, 11'd5);
    push_item(ACT_CLEAR, 8'hFF, 11'h7FF);
    push_item(ACT_READ, 8'h00, 11'd0);
    push_item(ACT_SPARE_FIRST, 8'hFF, 11'h7FF);
    push_item(ACT_SPARE_FIRST + 1'b1, 8'h00, 11'd0);
    push_item(ACT_SPARE_LAST, 8'hFF, 11'h7FF);
    push_item(ACT_WRITE, 8'h3C, 11'h7FF);

    for (int p = 0; p < NUM_PHASES; p++) begin
      program_depth(PHASE_DEPTH[p]);
      calm = (p == CALM_PHASE);
      if (p == 0) begin
        // capacity two: third write pushes out the oldest
        push_item(ACT_WRITE, 8'h11, 11'd0);
        push_item(ACT_WRITE, 8'h22, 11'd0);
        push_item(ACT_WRITE, 8'h33, 11'd0);
        push_item(ACT_PEEK, 8'h00, 11'd1);
        push_item(ACT_READ, 8'h00, 11'd0);
        push_item(ACT_READ, 8'h00, 11'd0);
        push_item(ACT_READ, 8'h00, 11'd0);
      end
      n = (p == FILL_PHASE) ? FILL_ITEMS : PHASE_ITEMS;
      for (int i = 0; i < n; i++) begin
        if (p == FILL_PHASE) calm = (i < CALM_ITEMS);
        random_item(p == FILL_PHASE);
      end
    end

    calm = 1'b0;
    in_valid_i <= 1'b0;
    while (pred.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pred.failures + pred.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    int unsigned hold_left;
    bit held;
    hold_left = 0;
    held = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else if (!held && n_results >= HOLD_AT) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !calm && ($urandom_range(99) < 11);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      pred.check_result(ring_result_t'{read_byte_o, byte_valid_o, moved_count_o,
                                       overwrote_o, fill_level_o, free_space_o});
      n_results++;
    end
  end

  initial begin
    int unsigned stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) stuck = 0;
      else stuck++;
    end
    $display("tb: failure");
    $finish;
  end

endmodule

>>> filelist.f
design/brfo_pkg.sv
design/byte_ring_fifo_overwrite_top.sv
bench/tb.sv
